// ----- rtl/fpadd_pkg.sv -----
// fpadd_pkg: shared types and constants for the fp32 adder pipeline
// no dependencies
`timescale 1ns / 1ps

package fpadd_pkg;

   localparam logic [7:0] ExpMax = 8'd255;
   localparam logic [31:0] NanInfDiff = 32'hFFA00000;

   // stage 1 to stage 2: aligned operands
   typedef struct packed {
      logic        sa;
      logic        sb;
      logic        sbig;
      logic [7:0]  ebig;
      logic [23:0] mbig;
      logic [26:0] part;
      logic        tsticky;
      logic        special;
      logic [31:0] special_word;
   } align_type;

   // stage 2 to stage 3: normalized sum before rounding
   typedef struct packed {
      logic        sa;
      logic        sb;
      logic        sbig;
      logic [7:0]  exp_r;
      logic [26:0] man_f;
      logic        sticky;
      logic        special;
      logic [31:0] special_word;
   } norm_type;

   function automatic logic [4:0] lzc26(input logic [25:0] v);
      logic [4:0] n;
      n = 5'd26;
      for (int b = 0; b <= 25; b++) begin
         if (v[b]) n = 5'(25 - b);
      end
      return n;
   endfunction

endpackage

// ----- rtl/fp32_adder_core.sv -----
// fp32_adder_core: pipelined IEEE-754 single-precision adder, top level
// depends on fpadd_pkg, fpadd_align, fpadd_norm, fpadd_round
//
// usage:
//   a transaction is accepted at a rising edge with start high and
//   busy low; busy is tied low, so one add may start every cycle
//   req_operand_a and req_operand_b carry the two addends
//   the sum appears on rsp_sum_word with rsp_valid high for one cycle,
//   after passing the input register, align, add/normalize and
//   round/pack stages
//   throughput is one transaction per cycle
//   synchronous reset clears all valid bits; in-flight transactions are dropped
//   the receiver cannot stall; every result is taken in its strobe cycle
`timescale 1ns / 1ps

module fp32_adder_core import fpadd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_sum_word
);
   logic        v0_ff, v1_ff, v2_ff, v3_ff;
   logic [31:0] a_ff, b_ff, sum_ff, sum_in;
   align_type   al_in, al_ff;
   norm_type    nm_in, nm_ff;

   assign busy = 1'b0;

   fpadd_align u_align (.a(a_ff), .b(b_ff), .res(al_in));
   fpadd_norm  u_norm  (.d(al_ff), .res(nm_in));
   fpadd_round u_round (.d(nm_ff), .word(sum_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else begin
         v0_ff <= start; v1_ff <= v0_ff; v2_ff <= v1_ff; v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= req_operand_a;
      b_ff <= req_operand_b;
      al_ff <= al_in;
      nm_ff <= nm_in;
      sum_ff <= sum_in;
   end

   assign rsp_valid = v3_ff;
   assign rsp_sum_word = sum_ff;
endmodule

// ----- rtl/fpadd_align.sv -----
// fpadd_align: unpack, special cases, operand ordering and alignment shift
// depends on fpadd_pkg
`timescale 1ns / 1ps

module fpadd_align import fpadd_pkg::*; (
   input  logic [31:0] a,
   input  logic [31:0] b,
   output align_type   res
);
   logic        sa, sb, pick_b, nza, nzb;
   logic [7:0]  ea, eb, xa, xb, diff;
   logic [22:0] fa, fb;
   logic [23:0] ma, mb, msml;
   logic [4:0]  shift;
   logic [54:0] aligned;

   always_comb begin
      sa = a[31]; sb = b[31];
      ea = a[30:23]; eb = b[30:23];
      fa = a[22:0]; fb = b[22:0];
      ma = {ea != 8'd0, fa};
      mb = {eb != 8'd0, fb};
      xa = (ea != 8'd0) ? ea : 8'd1;
      xb = (eb != 8'd0) ? eb : 8'd1;
      if (xa >= xb) begin
         diff = xa - xb; pick_b = 1'b0;
      end else begin
         diff = xb - xa; pick_b = 1'b1;
      end
      shift = (diff > 8'd31) ? 5'd31 : diff[4:0];
      if (shift == 5'd0) pick_b = !(ma > mb);
      msml = pick_b ? ma : mb;
      aligned = {msml, 31'd0} >> shift;
      res.sa = sa;
      res.sb = sb;
      res.sbig = pick_b ? sb : sa;
      res.ebig = pick_b ? xb : xa;
      res.mbig = pick_b ? mb : ma;
      res.tsticky = aligned[28:0] != 29'd0;
      res.part = {1'b0, aligned[54:29]};
      nza = fa != 23'd0;
      nzb = fb != 23'd0;
      res.special = (ea == ExpMax) || (eb == ExpMax);
      if (ea == ExpMax && eb != ExpMax)
         res.special_word = {sa, ExpMax, nza, fa[21:0]};
      else if (eb == ExpMax && ea != ExpMax)
         res.special_word = {sb, ExpMax, nzb, fb[21:0]};
      else if (nzb)
         res.special_word = {sb, ExpMax, 1'b1, fb[21:0]};
      else if (nza)
         res.special_word = {sa, ExpMax, 1'b1, fa[21:0]};
      else if (sa == sb)
         res.special_word = {sa, ExpMax, 23'd0};
      else
         res.special_word = NanInfDiff;
   end
endmodule

// ----- rtl/fpadd_norm.sv -----
// fpadd_norm: mantissa add or subtract and leading-zero normalization
// depends on fpadd_pkg
`timescale 1ns / 1ps

module fpadd_norm import fpadd_pkg::*; (
   input  align_type d,
   output norm_type  res
);
   logic [26:0] raw, man_d;
   logic [8:0]  einc;
   logic [7:0]  exp_d;
   logic        sticky;
   logic [4:0]  lz, sh;
   logic [9:0]  exp_f;

   always_comb begin
      sh = 5'd0;
      raw = (d.sa == d.sb) ? ({1'b0, d.mbig, 2'b00} + d.part)
                           : ({1'b0, d.mbig, 2'b00} - d.part);
      einc = {1'b0, d.ebig} + 9'd1;
      if (raw[26]) begin
         exp_d = (einc == 9'd255) ? ExpMax : einc[7:0];
         man_d = (einc == 9'd255) ? {1'b1, 26'd0} : {1'b0, raw[26:1]};
         sticky = d.tsticky | raw[0];
      end else begin
         exp_d = d.ebig;
         man_d = raw;
         sticky = d.tsticky;
      end
      lz = lzc26(man_d[25:0]);
      exp_f = {2'b00, exp_d} - {5'd0, lz};
      if (!exp_f[9] && exp_f != 10'd0) begin
         res.man_f = man_d << lz;
         res.exp_r = exp_f[7:0];
      end else begin
         sh = (exp_d[4:0] != 5'd0) ? exp_d[4:0] - 5'd1 : 5'd0;
         res.man_f = man_d << sh;
         res.exp_r = 8'd0;
      end
      res.sa = d.sa;
      res.sb = d.sb;
      res.sbig = d.sbig;
      res.sticky = sticky;
      res.special = d.special;
      res.special_word = d.special_word;
   end
endmodule

// ----- rtl/fpadd_round.sv -----
// fpadd_round: rounding, packing and special-case selection
// depends on fpadd_pkg
`timescale 1ns / 1ps

module fpadd_round import fpadd_pkg::*; (
   input  norm_type    d,
   output logic [31:0] word
);
   logic        g, r, l, up, sy;
   logic [24:0] man_r;
   logic [7:0]  ey;
   logic [22:0] my;

   always_comb begin
      g = d.man_f[1]; r = d.man_f[0]; l = d.man_f[2];
      up = (g && !r && !d.sticky && l) || (g && !r && (d.sa == d.sb) && d.sticky)
           || (g && r);
      man_r = d.man_f[26:2] + {24'd0, up};
      if (man_r[24]) begin
         ey = d.exp_r + 8'd1; my = 23'd0;
      end else if (man_r[23:0] == 24'd0) begin
         ey = 8'd0; my = 23'd0;
      end else begin
         ey = d.exp_r; my = man_r[22:0];
      end
      sy = (ey == 8'd0 && my == 23'd0) ? (d.sa & d.sb) : d.sbig;
      word = d.special ? d.special_word : {sy, ey, my};
   end
endmodule

// ----- rtl/fpadd_checker.sv -----
// fpadd_checker: port-level assertions for fp32_adder_core, bound to the top
// depends on fp32_adder_core ports only
`timescale 1ns / 1ps

module fpadd_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_operand_a,
   input logic [31:0] req_operand_b,
   input logic        rsp_valid,
   input logic [31:0] rsp_sum_word
);
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid) else $error("missing result");
   a_noinv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4)) else $error("spurious result");
   a_inf: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operand_a[30:23] == 8'd255 && req_operand_b[30:23] != 8'd255)
      |-> ##4 (rsp_sum_word[30:23] == 8'd255)) else $error("inf not passed");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
endmodule

bind fp32_adder_core fpadd_checker u_fpadd_checker (.*);
